// ===== rtl/encoder_offset_calibrator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Encoder offset calibrator assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ENCODER_OFFSET_CALIBRATOR_TOP_MACROS_SVH
`define ENCODER_OFFSET_CALIBRATOR_TOP_MACROS_SVH

// same-cycle implication
`define EOC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eoc check failed");

// next-cycle implication
`define EOC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eoc check failed");

`endif

// ===== rtl/eoc_pkg.sv =====
// ----------------------------------------------------------------------------
// eoc_pkg
// Types, codes and microcode table of the encoder offset calibrator.
// ----------------------------------------------------------------------------
package eoc_pkg;

    localparam int SAMPLE_W = 14;
    localparam int CPT_W    = 15;
    localparam int TOL_W    = 14;
    localparam int NP_W     = 4;
    localparam int OFF_W    = 18;
    localparam int CFG_W    = 15;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_POLES = 2'd0;
    localparam logic [IDX_W-1:0] REG_CPT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_TOL   = 2'd2;

    localparam logic [NP_W-1:0]  POLES_RST = 4'd7;
    localparam logic [CPT_W-1:0] CPT_RST   = 15'd16384;
    localparam logic [TOL_W-1:0] TOL_RST   = 14'd64;

    typedef enum logic [1:0] {
        STAT_IDLE,
        STAT_OK,
        STAT_REV,
        STAT_ERR
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_S,
        OP_DIV,
        OP_STORE,
        OP_SUM_CLR,
        OP_SUM_ACC,
        OP_DIR_LIM,
        OP_DIR_TEST,
        OP_CHK_MUL,
        OP_CHK_CMP,
        OP_INC,
        OP_LOAD_O,
        OP_SAVE_O,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_NO_IN,
        JC_DIV_MORE,
        JC_NOT_END,
        JC_MORE,
        JC_DIR_BAD,
        JC_DEV_BAD,
        JC_OUT_BUSY
    } jc_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_S,
        S_STORE,
        S_SUM_CLR,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIR_LIM,
        S_DIR_TEST,
        S_CHK_RD,
        S_CHK_MUL,
        S_CHK_CMP,
        S_CHK_NEXT,
        S_OFF_LOAD,
        S_DIV_O,
        S_OFF_SAVE,
        S_EMIT
    } step_t;

    typedef struct packed {
        op_t   op;
        jc_t   jc;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic round_end;
        logic more;
        logic dir_bad;
        logic dev_bad;
        logic out_busy;
    } flags_t;

    typedef struct packed {
        logic [NP_W-1:0]  poles;
        logic [CPT_W-1:0] cpt;
        logic [TOL_W-1:0] tol;
    } cfg_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        case (s)
            S_IDLE:     w = '{OP_LOAD_S,   JC_NO_IN,    S_IDLE};
            S_DIV_S:    w = '{OP_DIV,      JC_DIV_MORE, S_DIV_S};
            S_STORE:    w = '{OP_STORE,    JC_NOT_END,  S_EMIT};
            S_SUM_CLR:  w = '{OP_SUM_CLR,  JC_NONE,     S_IDLE};
            S_SUM_RD:   w = '{OP_NOP,      JC_NONE,     S_IDLE};
            S_SUM_ACC:  w = '{OP_SUM_ACC,  JC_MORE,     S_SUM_RD};
            S_DIR_LIM:  w = '{OP_DIR_LIM,  JC_NONE,     S_IDLE};
            S_DIR_TEST: w = '{OP_DIR_TEST, JC_DIR_BAD,  S_EMIT};
            S_CHK_RD:   w = '{OP_NOP,      JC_NONE,     S_IDLE};
            S_CHK_MUL:  w = '{OP_CHK_MUL,  JC_NONE,     S_IDLE};
            S_CHK_CMP:  w = '{OP_CHK_CMP,  JC_DEV_BAD,  S_EMIT};
            S_CHK_NEXT: w = '{OP_INC,      JC_MORE,     S_CHK_RD};
            S_OFF_LOAD: w = '{OP_LOAD_O,   JC_NONE,     S_IDLE};
            S_DIV_O:    w = '{OP_DIV,      JC_DIV_MORE, S_DIV_O};
            S_OFF_SAVE: w = '{OP_SAVE_O,   JC_NONE,     S_IDLE};
            S_EMIT:     w = '{OP_EMIT,     JC_OUT_BUSY, S_EMIT};
            default:    w = '{OP_NOP,      JC_NONE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/eoc_ram.sv =====
// ----------------------------------------------------------------------------
// eoc_ram
// Sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module eoc_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/eoc_seq.sv =====
// ----------------------------------------------------------------------------
// eoc_seq
// Step counter and microcode table; conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module eoc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  eoc_pkg::flags_t flags,
    output eoc_pkg::ctrl_t  ctrl
);

    import eoc_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    ctrl_t word;
    logic  take;

    always_comb
    begin
        word = ucode(pc_reg);
    end

    always_comb
    begin
        case (word.jc)
            JC_NONE:     take = 1'b0;
            JC_NO_IN:    take = !flags.in_valid;
            JC_DIV_MORE: take = flags.div_more;
            JC_NOT_END:  take = !flags.round_end;
            JC_MORE:     take = flags.more;
            JC_DIR_BAD:  take = flags.dir_bad;
            JC_DEV_BAD:  take = flags.dev_bad;
            JC_OUT_BUSY: take = flags.out_busy;
            default:     take = 1'b0;
        endcase
        // last step falls through to the first
        pc_next = take ? word.target : step_t'(pc_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

// ===== rtl/eoc_dp.sv =====
// ----------------------------------------------------------------------------
// eoc_dp
// Datapath: sample reduction, shift-subtract divider, round sums and checks,
// output register.
// ----------------------------------------------------------------------------
module eoc_dp #(
    parameter int MAX_POLES = 8,
    parameter int ENC_BITS  = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  eoc_pkg::ctrl_t              ctrl,
    input  eoc_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  logic [ENC_BITS-1:0]         encoder_count,
    input  logic                        out_ready,
    output eoc_pkg::flags_t             flags,
    output logic                        out_valid,
    output logic [1:0]                  next_angle_index,
    output logic [1:0]                  round_status,
    output logic [eoc_pkg::OFF_W-1:0]   zero_offset
);

    import eoc_pkg::*;

    localparam int PIW   = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
    localparam int AW    = PIW + 2;
    localparam int DEPTH = MAX_POLES * 4;
    localparam int NW    = $clog2(MAX_POLES + 1);
    localparam int RW    = SAMPLE_W + $clog2(2 * MAX_POLES);
    localparam int LW    = NW + 1 + TOL_W;
    localparam int XW    = ((RW > LW) ? RW : LW) + 1;
    localparam int SDW   = (ENC_BITS > CPT_W) ? ENC_BITS : CPT_W;
    localparam int DW    = (SDW > RW + 3) ? SDW : RW + 3;
    localparam int CNT_W = $clog2(DW);
    localparam int NUMW  = ((ENC_BITS > CPT_W) ? ENC_BITS + 2 : CPT_W + 2) + 1;

    logic [1:0]          angle_reg,  angle_next;
    logic [PIW-1:0]      pole_reg,   pole_next;
    status_t             status_reg, status_next;
    logic [OFF_W-1:0]    offset_reg, offset_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [AW-1:0]       addr_reg,   addr_next;
    logic                out_valid_reg, out_valid_next;

    logic [DW-1:0]       quo_reg,  quo_next;
    logic [CPT_W-1:0]    rem_reg,  rem_next;
    logic [CPT_W-1:0]    dvs_reg,  dvs_next;
    logic [RW-1:0]       raw1_reg, raw1_next;
    logic [RW-1:0]       raw2_reg, raw2_next;
    logic [RW-1:0]       diff_reg, diff_next;
    logic [LW-1:0]       lim_reg,  lim_next;
    logic [LW-1:0]       prod_reg, prod_next;
    logic [1:0]          oang_reg, oang_next;
    status_t             ostat_reg, ostat_next;
    logic [OFF_W-1:0]    ooff_reg, ooff_next;

    logic [SAMPLE_W-1:0] rd_data;
    logic                mem_we;

    logic [NP_W:0]       pz;
    logic [NW-1:0]       n_use;
    logic [NW:0]         two_n;
    logic [NW+1:0]       n4m1;
    logic [AW-1:0]       last_addr;
    logic [PIW-1:0]      pole_inc;
    logic                wrap;
    logic                round_end;
    logic                more;
    logic                out_busy;

    logic [CPT_W+1:0]    ck;
    logic signed [NUMW-1:0] num;
    logic [NUMW-1:0]     mag;
    logic [NUMW-3:0]     q;
    logic [SDW-1:0]      samp;

    logic [CPT_W:0]      trial;
    logic                ge;
    logic [CPT_W-1:0]    rem_step;

    logic [RW:0]         raw_sum;
    logic [RW-1:0]       raw_sel;
    logic [XW-1:0]       dev_a, dev_b, dev;
    logic                dir_bad;
    logic                dev_bad;

    // pole count in use and round bookkeeping
    always_comb
    begin
        pz = {1'b0, cfg.poles};
        if (pz == '0)
        begin
            n_use = NW'(1);
        end
        else if (pz > (NP_W + 1)'(MAX_POLES))
        begin
            n_use = NW'(MAX_POLES);
        end
        else
        begin
            n_use = NW'(pz);
        end
        two_n     = {n_use, 1'b0};
        n4m1      = {n_use, 2'b00} - (NW + 2)'(1);
        last_addr = n4m1[AW-1:0];
        pole_inc  = (pole_reg == PIW'(MAX_POLES - 1)) ? '0 : pole_reg + PIW'(1);
        wrap      = (angle_reg == 2'd3);
        round_end = wrap && ((pole_inc == '0) || (NW'(pole_inc) >= n_use));
        more      = (addr_reg != last_addr);
        out_busy  = out_valid_reg && !out_ready;
    end

    // sample before reduction modulo the turn count
    always_comb
    begin
        ck  = (CPT_W + 2)'(cfg.cpt) * (CPT_W + 2)'(angle_reg);
        num = $signed(NUMW'({encoder_count, 2'b00})) - $signed(NUMW'(ck));
        mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        q   = mag[NUMW-1:2];
        if (cfg.cpt == '0)
        begin
            samp = '0;
        end
        else if (num[NUMW-1] && (q != '0))
        begin
            samp = SDW'(cfg.cpt - q[CPT_W-1:0]);
        end
        else
        begin
            samp = SDW'(q);
        end
    end

    // one restoring divide step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_step = ge ? CPT_W'(trial - {1'b0, dvs_reg}) : trial[CPT_W-1:0];
    end

    // round checks
    always_comb
    begin
        raw_sum = (RW + 1)'(raw1_reg) + (RW + 1)'(raw2_reg);
        raw_sel = addr_reg[0] ? raw2_reg : raw1_reg;
        dev_a   = XW'(raw_sel);
        dev_b   = XW'(prod_reg);
        dev     = (dev_a >= dev_b) ? dev_a - dev_b : dev_b - dev_a;
        dev_bad = (dev > XW'(lim_reg));
        dir_bad = (XW'(diff_reg) > XW'(lim_reg));
    end

    always_comb
    begin
        angle_next     = angle_reg;
        pole_next      = pole_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        raw1_next      = raw1_reg;
        raw2_next      = raw2_reg;
        diff_next      = diff_reg;
        lim_next       = lim_reg;
        prod_next      = prod_reg;
        oang_next      = oang_reg;
        ostat_next     = ostat_reg;
        ooff_next      = ooff_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (ctrl.op)
            OP_LOAD_S:
            begin
                if (in_valid)
                begin
                    quo_next = DW'(samp);
                    rem_next = '0;
                    dvs_next = cfg.cpt;
                    cnt_next = CNT_W'(DW - 1);
                end
            end
            OP_DIV:
            begin
                quo_next = {quo_reg[DW-2:0], ge};
                rem_next = rem_step;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            OP_STORE:
            begin
                mem_we     = 1'b1;
                angle_next = angle_reg + 2'd1;
                if (wrap)
                begin
                    pole_next = round_end ? '0 : pole_inc;
                end
            end
            OP_SUM_CLR:
            begin
                raw1_next = '0;
                raw2_next = '0;
                addr_next = '0;
            end
            OP_SUM_ACC:
            begin
                if (addr_reg[0])
                begin
                    raw2_next = raw2_reg + RW'(rd_data);
                end
                else
                begin
                    raw1_next = raw1_reg + RW'(rd_data);
                end
                if (more)
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            OP_DIR_LIM:
            begin
                lim_next  = LW'(two_n) * LW'(cfg.cpt[CPT_W-1:2]);
                diff_next = (raw1_reg >= raw2_reg) ? raw1_reg - raw2_reg
                                                   : raw2_reg - raw1_reg;
            end
            OP_DIR_TEST:
            begin
                if (dir_bad)
                begin
                    status_next = STAT_REV;
                end
                else
                begin
                    lim_next  = LW'(two_n) * LW'(cfg.tol);
                    addr_next = '0;
                end
            end
            OP_CHK_MUL:
            begin
                prod_next = LW'(two_n) * LW'(rd_data);
            end
            OP_CHK_CMP:
            begin
                if (dev_bad)
                begin
                    status_next = STAT_ERR;
                end
            end
            OP_INC:
            begin
                if (more)
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            OP_LOAD_O:
            begin
                quo_next = DW'({raw_sum, 2'b00});
                rem_next = '0;
                dvs_next = CPT_W'(n_use);
                cnt_next = CNT_W'(DW - 1);
            end
            OP_SAVE_O:
            begin
                offset_next = quo_reg[OFF_W-1:0];
                status_next = STAT_OK;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    oang_next      = angle_reg;
                    ostat_next     = status_reg;
                    ooff_next      = offset_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= '0;
            pole_reg      <= '0;
            status_reg    <= STAT_IDLE;
            offset_reg    <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            angle_reg     <= angle_next;
            pole_reg      <= pole_next;
            status_reg    <= status_next;
            offset_reg    <= offset_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        raw1_reg  <= raw1_next;
        raw2_reg  <= raw2_next;
        diff_reg  <= diff_next;
        lim_reg   <= lim_next;
        prod_reg  <= prod_next;
        oang_reg  <= oang_next;
        ostat_reg <= ostat_next;
        ooff_reg  <= ooff_next;
    end

    eoc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({pole_reg, angle_reg}),
        .wdata (rem_reg[SAMPLE_W-1:0]),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign flags.in_valid  = in_valid;
    assign flags.div_more  = (cnt_reg != '0);
    assign flags.round_end = round_end;
    assign flags.more      = more;
    assign flags.dir_bad   = dir_bad;
    assign flags.dev_bad   = dev_bad;
    assign flags.out_busy  = out_busy;

    assign out_valid        = out_valid_reg;
    assign next_angle_index = oang_reg;
    assign round_status     = ostat_reg;
    assign zero_offset      = ooff_reg;

endmodule

// ===== rtl/encoder_offset_calibrator_top.sv =====
// ----------------------------------------------------------------------------
// Encoder offset calibrator
// Encoder readings in, one status word out per reading.
// ----------------------------------------------------------------------------
// Input word: encoder_count, taken on in_valid && in_ready while the angle
// last reported in next_angle_index is commanded. Every input word yields one
// output word (next_angle_index, round_status, zero_offset) on
// out_valid && out_ready. Registers are written on cfg_we at cfg_index.
// One word at a time: in_ready is high only while the sequencer waits.
// Ordinary word: accept, then a bit-serial modulo in the divider, whose
// width DW is 21 at default parameters, then store and out_valid.
// The last word of a round (N poles) adds two walks over the sample store
// and then the divide that forms the offset.
// A stalled output holds its word; the next input is still accepted and
// its result waits in the final step until the output register frees.
// Reset returns the sequencer to idle, angle and pole to zero, status and
// offset to zero, registers to 7, 16384 and 64. The sample store is not
// cleared.
// ----------------------------------------------------------------------------
module encoder_offset_calibrator_top #(
    parameter int MAX_POLES = 8,
    parameter int ENC_BITS  = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [eoc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [eoc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ENC_BITS-1:0]         encoder_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  next_angle_index,
    output logic [1:0]                  round_status,
    output logic [eoc_pkg::OFF_W-1:0]   zero_offset
);

    import eoc_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    ctrl_t  ctrl;
    flags_t flags;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_POLES: cfg_next.poles = cfg_data[NP_W-1:0];
                REG_CPT:   cfg_next.cpt   = cfg_data[CPT_W-1:0];
                REG_TOL:   cfg_next.tol   = cfg_data[TOL_W-1:0];
                default:   cfg_next       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{POLES_RST, CPT_RST, TOL_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = (ctrl.op == OP_LOAD_S);

    eoc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    eoc_dp #(
        .MAX_POLES (MAX_POLES),
        .ENC_BITS  (ENC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .encoder_count    (encoder_count),
        .out_ready        (out_ready),
        .flags            (flags),
        .out_valid        (out_valid),
        .next_angle_index (next_angle_index),
        .round_status     (round_status),
        .zero_offset      (zero_offset)
    );

endmodule

// ===== rtl/eoc_chk.sv =====
// ----------------------------------------------------------------------------
// eoc_chk
// Port-level checks of the encoder offset calibrator, bound to the top.
// ----------------------------------------------------------------------------
`include "encoder_offset_calibrator_top_macros.svh"

module eoc_chk #(
    parameter int ENC_BITS = 14
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_we,
    input logic [eoc_pkg::IDX_W-1:0]   cfg_index,
    input logic [eoc_pkg::CFG_W-1:0]   cfg_data,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [ENC_BITS-1:0]         encoder_count,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [1:0]                  next_angle_index,
    input logic [1:0]                  round_status,
    input logic [eoc_pkg::OFF_W-1:0]   zero_offset
);

    import eoc_pkg::*;

    logic [1:0]       exp_angle_reg;
    logic [1:0]       prev_status_reg;
    logic [OFF_W-1:0] prev_offset_reg;
    logic             seen_reg;
    logic             out_fire;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_angle_reg   <= 2'd1;
            prev_status_reg <= '0;
            prev_offset_reg <= '0;
            seen_reg        <= 1'b0;
        end
        else if (out_fire)
        begin
            exp_angle_reg   <= next_angle_index + 2'd1;
            prev_status_reg <= round_status;
            prev_offset_reg <= zero_offset;
            seen_reg        <= 1'b1;
        end
    end

    `EOC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(next_angle_index) && $stable(round_status) && $stable(zero_offset))
    `EOC_ASSERT_IMP(a_angle_seq, clk, rst_n, out_valid, next_angle_index == exp_angle_reg)
    `EOC_ASSERT_IMP(a_idle_offset, clk, rst_n, out_valid && round_status == STAT_IDLE,
        zero_offset == '0)
    `EOC_ASSERT_IMP(a_change_at_wrap, clk, rst_n,
        out_valid && seen_reg && (round_status != prev_status_reg || zero_offset != prev_offset_reg),
        next_angle_index == 2'd0)
    `EOC_ASSERT_IMP(a_offset_on_ok, clk, rst_n,
        out_valid && seen_reg && zero_offset != prev_offset_reg, round_status == STAT_OK)

endmodule

bind encoder_offset_calibrator_top eoc_chk #(.ENC_BITS(ENC_BITS)) u_chk (.*);
